// ----- sv/mg3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mg3_pkg
// Shared constants, payload types, stage structs and helper functions of the
// 3x3 morphological gradient block.
// ----------------------------------------------------------------------------
package mg3_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH    = 1024;
   localparam int WINDOW_SIZE  = 3;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int CELLS        = WINDOW_SIZE * WINDOW_SIZE;

   // field and counter widths
   localparam int PIXEL_BITS     = 8;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 1;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS    = $clog2(HEIGHT_LIMIT + 1);
   localparam int ROW_BITS       = $clog2(HEIGHT_LIMIT + 3);
   localparam int OUT_ROW_BITS   = $clog2(HEIGHT_LIMIT);

   // register reset values
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_BITS'(1);

   // request operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [PIXEL_BITS-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] gradient;
      logic                  frame_last;
   } rsp_type;

   // one stream step, from position control to the row memory stage
   typedef struct packed {
      logic                   valid;
      logic                   emit;
      logic                   last;
      logic                   col_zero;
      logic [PIXEL_BITS-1:0]  pixel;
      logic [COL_BITS-1:0]    addr;
      logic [WINDOW_SIZE-1:0] row_mask;
      logic [WINDOW_SIZE-1:0] col_mask;
   } stage1_type;

   // masked window cells, ready for the max and min reduction
   typedef struct packed {
      logic                             valid;
      logic                             last;
      logic [CELLS-1:0][PIXEL_BITS-1:0] hi_cand;
      logic [CELLS-1:0][PIXEL_BITS-1:0] lo_cand;
   } stage2_type;

   // clamp a written width to 1..MAX_WIDTH
   function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [CSR_DATA_BITS-1:0] value);
      int unsigned t;
      t = value;
      if (t == 0) t = 1;
      else if (t > MAX_WIDTH) t = MAX_WIDTH;
      return WIDTH_BITS'(t);
   endfunction

   // clamp a written height to 1..HEIGHT_LIMIT
   function automatic logic [HEIGHT_BITS-1:0] clamp_height(input logic [CSR_DATA_BITS-1:0] value);
      int unsigned t;
      t = value;
      if (t == 0) t = 1;
      else if (t > HEIGHT_LIMIT) t = HEIGHT_LIMIT;
      return HEIGHT_BITS'(t);
   endfunction

endpackage
`default_nettype wire

// ----- sv/morphological_gradient_3x3_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// morphological_gradient_3x3_top
// 3x3 grayscale morphological gradient (dilation minus erosion) over a
// raster-order pixel stream, with border pixels left out of the window.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req_stall is low: a pixel
// request or a drain request. That rate is set by the row memory, which
// holds the two previous rows in one word per column and is read and written
// back once per step, with the write of one step forwarded to the next when
// both hit the same column. The first drain of a one-row frame moves the
// stream position twice and holds req_stall high for the extra step.
// The gradient for a pixel passes the s1, s2 and s3 stage registers and the
// response register after the request that completes its window (the pixel
// one row down and one column right); after the last pixel of a frame,
// width + 1 drain requests (width in a one-row frame) flush the remaining
// outputs, and the last one carries frame_last. The row memory needs no
// clearing after reset. A two-entry response buffer holds one more response
// behind a stalled one before requests stall. Register writes restart the
// frame position and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
module morphological_gradient_3x3_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire mg3_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output mg3_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mg3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mg3_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                pipe_enable;
   mg3_pkg::stage1_type stage0;
   mg3_pkg::stage2_type stage2;

   // stream position and registers
   mg3_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .pipe_enable (pipe_enable),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .stage0      (stage0)
   );

   // row memory and window
   mg3_rows u_rows (
      .clock       (clock),
      .reset       (reset),
      .pipe_enable (pipe_enable),
      .stage0      (stage0),
      .stage2      (stage2)
   );

   // reduction and response buffer
   mg3_out u_out (
      .clock       (clock),
      .reset       (reset),
      .stage2      (stage2),
      .pipe_enable (pipe_enable),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sv/mg3_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mg3_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mg3_ram #(
   parameter int DEPTH = mg3_pkg::MAX_WIDTH,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/mg3_ctl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mg3_ctl
// Frame position control: registers, input and output raster counters,
// emit decision, border masks and the extra step of a one-row drain.
// ----------------------------------------------------------------------------
module mg3_ctl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  pipe_enable,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire mg3_pkg::req_type                      req_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mg3_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [mg3_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output mg3_pkg::stage1_type                        stage0
);

   logic [mg3_pkg::WIDTH_BITS-1:0]   width_ff;
   logic [mg3_pkg::HEIGHT_BITS-1:0]  height_ff;
   logic [mg3_pkg::COL_BITS-1:0]     in_col_ff, in_col_in, col_e;
   logic [mg3_pkg::ROW_BITS-1:0]     in_row_ff, in_row_in, row_e;
   logic [mg3_pkg::COL_BITS-1:0]     out_col_ff, out_col_in, out_col_e;
   logic [mg3_pkg::OUT_ROW_BITS-1:0] out_row_ff, out_row_in, out_row_e;
   logic                             done_ff, done_in, done_e;
   logic                             inject_ff, inject_in;
   logic [mg3_pkg::WIDTH_BITS-1:0]   width_last;
   logic [mg3_pkg::HEIGHT_BITS-1:0]  height_last;
   logic csr_write, accept, is_pixel, is_drain, frame_over, restart, drain_go;
   logic advance, started, emit, col_end, out_col_end, out_row_end, out_last, col_zero;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_stall = ~pipe_enable | inject_ff;
   assign accept    = req_valid & ~req_stall;

   assign width_last  = width_ff - 1'b1;
   assign height_last = height_ff - 1'b1;

   // request decode and step decision
   always_comb begin
      is_pixel   = accept & (req_data.op == mg3_pkg::OP_PIXEL);
      is_drain   = accept & (req_data.op == mg3_pkg::OP_DRAIN);
      frame_over = int'(in_row_ff) >= int'(height_ff);
      restart    = is_pixel & frame_over;
      drain_go   = is_drain & frame_over & ~done_ff;
      advance    = is_pixel | drain_go | (inject_ff & pipe_enable);

      col_e     = restart ? '0 : in_col_ff;
      row_e     = restart ? '0 : in_row_ff;
      out_col_e = restart ? '0 : out_col_ff;
      out_row_e = restart ? '0 : out_row_ff;
      done_e    = restart ? 1'b0 : done_ff;

      // outputs start one row and one column behind the input
      started = (int'(row_e) >= 2) || ((int'(row_e) == 1) && (col_e != '0));
      emit    = advance & started & ~done_e;

      col_zero    = (col_e == '0);
      col_end     = (mg3_pkg::WIDTH_BITS'(col_e) == width_last);
      out_col_end = (mg3_pkg::WIDTH_BITS'(out_col_e) == width_last);
      out_row_end = (mg3_pkg::HEIGHT_BITS'(out_row_e) == height_last);
      out_last    = out_col_end & out_row_end;
   end

   // next counter values
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      done_in    = done_ff;
      inject_in  = inject_ff;
      if (pipe_enable) begin
         inject_in = drain_go & ~started;
      end
      if (advance) begin
         if (col_end) begin
            in_col_in = '0;
            in_row_in = row_e + 1'b1;
         end else begin
            in_col_in = col_e + 1'b1;
            in_row_in = row_e;
         end
         out_col_in = out_col_e;
         out_row_in = out_row_e;
         done_in    = done_e;
         if (emit) begin
            if (out_col_end) begin
               out_col_in = '0;
               out_row_in = out_row_e + 1'b1;
            end else begin
               out_col_in = out_col_e + 1'b1;
            end
            done_in = out_last;
         end
      end
   end

   // step descriptor with border masks
   always_comb begin
      stage0.valid       = advance;
      stage0.emit        = emit;
      stage0.last        = out_last;
      stage0.col_zero    = col_zero;
      stage0.pixel       = is_pixel ? req_data.pixel : '0;
      stage0.addr        = col_e;
      stage0.row_mask[0] = (out_row_e != '0);
      stage0.row_mask[1] = 1'b1;
      stage0.row_mask[2] = ~out_row_end;
      stage0.col_mask[0] = col_zero ? (int'(width_ff) >= 3) : (int'(col_e) >= 2);
      stage0.col_mask[1] = col_zero ? (int'(width_ff) >= 2) : 1'b1;
      stage0.col_mask[2] = 1'b1;
   end

   // registers and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= mg3_pkg::clamp_width(mg3_pkg::CSR_DATA_BITS'(mg3_pkg::WIDTH_RESET));
         height_ff  <= mg3_pkg::clamp_height(mg3_pkg::CSR_DATA_BITS'(mg3_pkg::HEIGHT_RESET));
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         done_ff    <= 1'b0;
         inject_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            mg3_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= mg3_pkg::clamp_width(csr_wdata);
            end
            mg3_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= mg3_pkg::clamp_height(csr_wdata);
            end
            default: begin
            end
         endcase
         // a register write restarts the frame
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         done_ff    <= 1'b0;
         inject_ff  <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         done_ff    <= done_in;
         inject_ff  <= inject_in;
      end
   end

   // the extra step of a one-row drain always yields an output
   a_inject_emits: assert property (@(posedge clock) disable iff (reset)
      inject_ff && pipe_enable |-> emit)
      else $error("extra drain step gave no output");

   // the extra step is only ever requested by a drain
   a_inject_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(inject_ff) |-> $past(drain_go))
      else $error("extra drain step without a drain request");

   // the frame is only finished once input is past the last row
   a_done_position: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> int'(in_row_ff) > int'(height_ff))
      else $error("frame finished before input left the frame");

endmodule
`default_nettype wire

// ----- sv/mg3_rows.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mg3_rows
// Row memory read-modify-write with same-address forwarding, the 3x3 window
// and the border-masked cells handed to the reduction.
// ----------------------------------------------------------------------------
module mg3_rows (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pipe_enable,
   input  wire mg3_pkg::stage1_type stage0,
   output mg3_pkg::stage2_type      stage2
);

   mg3_pkg::stage1_type s1_ff;
   mg3_pkg::stage2_type s2_ff, s2_in;
   logic                                fwd_ff, fwd_in, wr_en;
   logic [2*mg3_pkg::PIXEL_BITS-1:0]    fwd_data_ff, ram_q, row_word, wr_word;
   logic [mg3_pkg::PIXEL_BITS-1:0]      win_ff  [mg3_pkg::WINDOW_SIZE][mg3_pkg::WINDOW_SIZE];
   logic [mg3_pkg::PIXEL_BITS-1:0]      shifted [mg3_pkg::WINDOW_SIZE][mg3_pkg::WINDOW_SIZE];
   logic [mg3_pkg::PIXEL_BITS-1:0]      new_col [mg3_pkg::WINDOW_SIZE];

   // both row stores in one word: upper row high, lower row low
   mg3_ram #(
      .DEPTH (mg3_pkg::MAX_WIDTH),
      .WIDTH (2 * mg3_pkg::PIXEL_BITS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.addr),
      .wr_data (wr_word),
      .rd_en   (stage0.valid),
      .rd_addr (stage0.addr),
      .rd_data (ram_q)
   );

   // forward the write of the step before when it hit the same column
   assign row_word = fwd_ff ? fwd_data_ff : ram_q;
   assign fwd_in   = stage0.valid & s1_ff.valid & (stage0.addr == s1_ff.addr);
   assign wr_en    = pipe_enable & s1_ff.valid;
   assign wr_word  = {new_col[1], s1_ff.pixel};

   // incoming column and shifted window
   always_comb begin
      new_col[0] = row_word[2*mg3_pkg::PIXEL_BITS-1:mg3_pkg::PIXEL_BITS];
      new_col[1] = row_word[mg3_pkg::PIXEL_BITS-1:0];
      new_col[2] = s1_ff.pixel;
      for (int i = 0; i < mg3_pkg::WINDOW_SIZE; i++) begin
         for (int j = 0; j < mg3_pkg::WINDOW_SIZE - 1; j++) begin
            shifted[i][j] = win_ff[i][j+1];
         end
         shifted[i][mg3_pkg::WINDOW_SIZE-1] = new_col[i];
      end
   end

   // masked cells: first column of a row looks at the window before the shift
   always_comb begin
      logic [mg3_pkg::PIXEL_BITS-1:0] pick;
      logic                           keep;
      s2_in.valid = s1_ff.valid & s1_ff.emit;
      s2_in.last  = s1_ff.last;
      for (int i = 0; i < mg3_pkg::WINDOW_SIZE; i++) begin
         for (int j = 0; j < mg3_pkg::WINDOW_SIZE; j++) begin
            pick = s1_ff.col_zero ? win_ff[i][j] : shifted[i][j];
            keep = s1_ff.row_mask[i] & s1_ff.col_mask[j];
            s2_in.hi_cand[i*mg3_pkg::WINDOW_SIZE+j] = keep ? pick : '0;
            s2_in.lo_cand[i*mg3_pkg::WINDOW_SIZE+j] = keep ? pick : '1;
         end
      end
   end

   // stage registers and forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (pipe_enable) begin
         s1_ff       <= stage0;
         s2_ff       <= s2_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_word;
      end
   end

   // window shift once per step
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mg3_pkg::WINDOW_SIZE; i++) begin
            for (int j = 0; j < mg3_pkg::WINDOW_SIZE; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (wr_en) begin
         for (int i = 0; i < mg3_pkg::WINDOW_SIZE; i++) begin
            for (int j = 0; j < mg3_pkg::WINDOW_SIZE; j++) begin
               win_ff[i][j] <= shifted[i][j];
            end
         end
      end
   end

   assign stage2 = s2_ff;

endmodule
`default_nettype wire

// ----- sv/mg3_out.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mg3_out
// Window max and min reduction, gradient subtract and a two-entry response
// buffer that decouples the pipeline from response stalls.
// ----------------------------------------------------------------------------
module mg3_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mg3_pkg::stage2_type stage2,
   output logic                     pipe_enable,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output mg3_pkg::rsp_type         rsp_data
);

   logic [mg3_pkg::PIXEL_BITS-1:0] hi_in, lo_in, hi_ff, lo_ff;
   logic                           s3_valid_ff, s3_last_ff;
   logic                           out_valid_ff, skid_valid_ff, new_valid, out_take;
   mg3_pkg::rsp_type               out_data_ff, skid_data_ff, new_data;

   assign pipe_enable = ~skid_valid_ff;

   // max and min over the masked cells
   always_comb begin
      hi_in = stage2.hi_cand[0];
      lo_in = stage2.lo_cand[0];
      for (int k = 1; k < mg3_pkg::CELLS; k++) begin
         if (stage2.hi_cand[k] > hi_in) hi_in = stage2.hi_cand[k];
         if (stage2.lo_cand[k] < lo_in) lo_in = stage2.lo_cand[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s3_valid_ff <= stage2.valid;
         s3_last_ff  <= stage2.last;
         hi_ff       <= hi_in;
         lo_ff       <= lo_in;
      end
   end

   // gradient entering the response buffer
   assign new_valid           = pipe_enable & s3_valid_ff;
   assign new_data.gradient   = hi_ff - lo_ff;
   assign new_data.frame_last = s3_last_ff;
   assign out_take            = out_valid_ff & ~rsp_stall;

   // response register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= new_valid;
            skid_data_ff  <= new_data;
         end else begin
            out_valid_ff <= new_valid;
            out_data_ff  <= new_data;
         end
      end else if (new_valid) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= new_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // skid entry only fills behind a held response
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a response ahead of the output register");

   // at least one cell is always inside the frame
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> hi_ff >= lo_ff)
      else $error("window maximum below window minimum");

endmodule
`default_nettype wire

// ----- sim/tb_morphological_gradient_3x3_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_morphological_gradient_3x3_top
// Self-checking bench for the 3x3 morphological gradient block. A short
// directed table covers reset, register clamping, drains and dropped outputs.
// It is followed by one wide partial frame at the register limits and by
// random frames, most of them well formed, with drains, noise and stalls on
// both sides. Responses are checked against listed values or an in-bench window model.
// ----------------------------------------------------------------------------
module tb_morphological_gradient_3x3_top;

   // directed plan row layout
   typedef enum logic [1:0] {ROW_REQUEST, ROW_WIDTH, ROW_HEIGHT} row_kind_type;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_VALUE} check_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic                              op;
      logic [mg3_pkg::CSR_DATA_BITS-1:0] value;
      check_kind_type                    check;
      logic [mg3_pkg::PIXEL_BITS-1:0]    gradient;
      logic                              last;
   } plan_row_type;

   localparam int PLAN_ROWS    = 29;
   localparam int RANDOM_ITEMS = 120;

   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // drain right after reset, frame not complete
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_NONE,  8'd0,   1'b0},
      // 2x2 frame, every window holds all four pixels
      '{ROW_WIDTH,   mg3_pkg::OP_PIXEL, 11'd2,   CHECK_NONE,  8'd0,   1'b0},
      '{ROW_HEIGHT,  mg3_pkg::OP_PIXEL, 11'd2,   CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd0,   CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd255, CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd255, CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd0,   CHECK_VALUE, 8'd255, 1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_VALUE, 8'd255, 1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_VALUE, 8'd255, 1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_VALUE, 8'd255, 1'b1},
      // nothing left to flush
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_NONE,  8'd0,   1'b0},
      // zero width and height clamp to a single pixel frame
      '{ROW_WIDTH,   mg3_pkg::OP_PIXEL, 11'd0,   CHECK_NONE,  8'd0,   1'b0},
      '{ROW_HEIGHT,  mg3_pkg::OP_PIXEL, 11'd0,   CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd77,  CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_VALUE, 8'd0,   1'b1},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_NONE,  8'd0,   1'b0},
      // one-row frame, then a new frame drops the undrained outputs
      '{ROW_WIDTH,   mg3_pkg::OP_PIXEL, 11'd3,   CHECK_NONE,  8'd0,   1'b0},
      '{ROW_HEIGHT,  mg3_pkg::OP_PIXEL, 11'd1,   CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd10,  CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd200, CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd30,  CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_MODEL, 8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd40,  CHECK_NONE,  8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd255, CHECK_MODEL, 8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_PIXEL, 11'd0,   CHECK_MODEL, 8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_MODEL, 8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_MODEL, 8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_MODEL, 8'd0,   1'b0},
      '{ROW_REQUEST, mg3_pkg::OP_DRAIN, 11'd0,   CHECK_MODEL, 8'd0,   1'b0}
   };

   // dut signals
   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   mg3_pkg::req_type                   req_data  = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   mg3_pkg::rsp_type                   rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [mg3_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mg3_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // window model state
   logic [mg3_pkg::CSR_DATA_BITS-1:0] width_setting;
   logic [mg3_pkg::CSR_DATA_BITS-1:0] height_setting;
   logic [mg3_pkg::PIXEL_BITS-1:0]    upper_row [mg3_pkg::MAX_WIDTH];
   logic [mg3_pkg::PIXEL_BITS-1:0]    lower_row [mg3_pkg::MAX_WIDTH];
   logic [mg3_pkg::PIXEL_BITS-1:0]    win [mg3_pkg::WINDOW_SIZE][mg3_pkg::WINDOW_SIZE];
   int                                col_pos;
   int                                row_pos;
   int                                emitted;

   // expected gradients in arrival order
   mg3_pkg::rsp_type pending_gradients [$];
   int               mismatches = 0;

   // stimulus shaping
   bit   steady_sender = 1'b0;
   int   useful_items  = 0;
   int   stall_left    = 0;
   logic stall_level   = 1'b0;

   always #4 clock = ~clock;

   morphological_gradient_3x3_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clamped frame geometry
   function automatic int active_width();
      int v;
      v = width_setting;
      if (v < 1) v = 1;
      if (v > mg3_pkg::MAX_WIDTH) v = mg3_pkg::MAX_WIDTH;
      return v;
   endfunction

   function automatic int active_height();
      int v;
      v = height_setting;
      if (v < 1) v = 1;
      if (v > mg3_pkg::HEIGHT_LIMIT) v = mg3_pkg::HEIGHT_LIMIT;
      return v;
   endfunction

   function automatic void predictor_reset();
      width_setting  = mg3_pkg::CSR_DATA_BITS'(mg3_pkg::WIDTH_RESET);
      height_setting = mg3_pkg::CSR_DATA_BITS'(mg3_pkg::HEIGHT_RESET);
      for (int k = 0; k < mg3_pkg::MAX_WIDTH; k++) begin
         upper_row[k] = '0;
         lower_row[k] = '0;
      end
      for (int i = 0; i < mg3_pkg::WINDOW_SIZE; i++)
         for (int j = 0; j < mg3_pkg::WINDOW_SIZE; j++)
            win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
   endfunction

   // any register write restarts the frame position
   function automatic void set_register(input logic [mg3_pkg::CSR_INDEX_BITS-1:0] idx,
                                        input logic [mg3_pkg::CSR_DATA_BITS-1:0] val);
      if (idx == mg3_pkg::CSR_FRAME_WIDTH) width_setting = val;
      else if (idx == mg3_pkg::CSR_FRAME_HEIGHT) height_setting = val;
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
   endfunction

   // max minus min over the in-frame cells around (r, c), centre at column cw
   function automatic logic [mg3_pkg::PIXEL_BITS-1:0] window_spread(input int r,
                                                                    input int c,
                                                                    input int cw,
                                                                    input int w,
                                                                    input int h);
      logic [mg3_pkg::PIXEL_BITS-1:0] hi;
      logic [mg3_pkg::PIXEL_BITS-1:0] lo;
      int                             rr;
      int                             cc;
      hi = '0;
      lo = '1;
      for (int i = 0; i < mg3_pkg::WINDOW_SIZE; i++) begin
         rr = r - 1 + i;
         if (rr < 0 || rr >= h) continue;
         for (int j = 0; j < mg3_pkg::WINDOW_SIZE; j++) begin
            cc = c - cw + j;
            if (cc < 0 || cc >= w) continue;
            if (win[i][j] > hi) hi = win[i][j];
            if (win[i][j] < lo) lo = win[i][j];
         end
      end
      return hi - lo;
   endfunction

   // one stream position: shift the window, update the rows, maybe emit
   function automatic bit stream_step(input logic [mg3_pkg::PIXEL_BITS-1:0] px,
                                      output mg3_pkg::rsp_type res);
      int                             w;
      int                             h;
      int                             n;
      int                             r;
      int                             c;
      int                             x;
      bit                             fire;
      logic [mg3_pkg::PIXEL_BITS-1:0] g;
      w    = active_width();
      h    = active_height();
      n    = w * h;
      fire = (row_pos * w + col_pos >= w + 1) && (emitted < n);
      r    = emitted / w;
      c    = emitted % w;
      x    = col_pos;
      g    = '0;
      res  = '0;
      // at column zero the centre is still one column behind the new data
      if (fire && x == 0) g = window_spread(r, c, 2, w, h);
      for (int i = 0; i < mg3_pkg::WINDOW_SIZE; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2]    = upper_row[x];
      win[1][2]    = lower_row[x];
      win[2][2]    = px;
      upper_row[x] = lower_row[x];
      lower_row[x] = px;
      if (fire && x != 0) g = window_spread(r, c, 1, w, h);
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (!fire) return 1'b0;
      res.gradient   = g;
      res.frame_last = (emitted == n - 1);
      emitted++;
      return 1'b1;
   endfunction

   // expected outcome of one accepted request
   function automatic bit predict_request(input logic op,
                                          input logic [mg3_pkg::PIXEL_BITS-1:0] px,
                                          output mg3_pkg::rsp_type res);
      int h;
      int n;
      h   = active_height();
      n   = active_width() * h;
      res = '0;
      if (op == mg3_pkg::OP_PIXEL) begin
         // pixel past the frame end opens a new frame
         if (row_pos >= h) begin
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
         end
         return stream_step(px, res);
      end
      if (row_pos < h || emitted >= n) return 1'b0;
      // a one-row frame needs a second step before the first output
      for (int k = 0; k < 2; k++)
         if (stream_step('0, res)) return 1'b1;
      return 1'b0;
   endfunction

   // hold requests until every expected gradient is back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_gradients.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mg3_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [mg3_pkg::CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      set_register(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drive one request after a random gap and wait for acceptance
   task automatic send_request(input logic op, input logic [mg3_pkg::PIXEL_BITS-1:0] px,
                               output bit has, output mg3_pkg::rsp_type res);
      int gap;
      int u;
      u = $urandom_range(0, 99);
      if (steady_sender || u < 55) gap = 0;
      else if (u < 82) gap = $urandom_range(1, 2);
      else if (u < 96) gap = $urandom_range(3, 8);
      else gap = $urandom_range(15, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op, pixel: px};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has = predict_request(op, px, res);
   endtask

   task automatic issue(input logic op, input logic [mg3_pkg::PIXEL_BITS-1:0] px);
      bit               has;
      mg3_pkg::rsp_type res;
      send_request(op, px, has, res);
      if (has) pending_gradients.push_back(res);
      if (has || op == mg3_pkg::OP_PIXEL) useful_items++;
   endtask

   // response check and random stall pattern
   always @(posedge clock) begin : rsp_side
      mg3_pkg::rsp_type want;
      int               u;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gradients.size() == 0) begin
            $display("%0t: unexpected response, gradient %0d last %0b",
                     $time, rsp_data.gradient, rsp_data.frame_last);
            mismatches++;
         end else begin
            want = pending_gradients.pop_front();
            if (rsp_data.gradient !== want.gradient) begin
               $display("%0t: gradient expected %0d got %0d",
                        $time, want.gradient, rsp_data.gradient);
               mismatches++;
            end
            if (rsp_data.frame_last !== want.frame_last) begin
               $display("%0t: frame_last expected %0b got %0b",
                        $time, want.frame_last, rsp_data.frame_last);
               mismatches++;
            end
         end
      end
      if (stall_left > 0) stall_left--;
      else begin
         u = $urandom_range(0, 99);
         if (u < 50) begin
            stall_level = 1'b0;
            stall_left  = $urandom_range(0, 6);
         end else if (u < 85) begin
            stall_level = 1'b1;
            stall_left  = $urandom_range(0, 2);
         end else if (u < 95) begin
            stall_level = 1'b1;
            stall_left  = $urandom_range(3, 12);
         end else if (u < 98) begin
            stall_level = 1'b0;
            stall_left  = $urandom_range(40, 150);
         end else begin
            stall_level = 1'b1;
            stall_left  = $urandom_range(20, 40);
         end
      end
      rsp_stall <= stall_level;
   end

   initial begin : stimulus
      plan_row_type                      row;
      bit                                has;
      mg3_pkg::rsp_type                  res;
      int                                w;
      int                                npix;
      int                                nsend;
      int                                ndrain;
      int                                hold_at;
      int                                pattern_mode;
      int                                pattern_base;
      int                                u;
      bit                                truncated;
      bit                                force_cfg;
      logic [mg3_pkg::CSR_DATA_BITS-1:0] wv;
      logic [mg3_pkg::CSR_DATA_BITS-1:0] hv;
      logic [mg3_pkg::PIXEL_BITS-1:0]    px;

      predictor_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = DIRECTED_PLAN[i];
         if (row.kind != ROW_REQUEST) begin
            settle();
            write_reg(row.kind == ROW_WIDTH ? mg3_pkg::CSR_FRAME_WIDTH
                                            : mg3_pkg::CSR_FRAME_HEIGHT, row.value);
         end else begin
            send_request(row.op, row.value[mg3_pkg::PIXEL_BITS-1:0], has, res);
            if (row.check == CHECK_VALUE)
               pending_gradients.push_back('{gradient: row.gradient, frame_last: row.last});
            else if (row.check == CHECK_MODEL && has)
               pending_gradients.push_back(res);
         end
      end

      // widest frame, width clamped from the register maximum, first rows only
      settle();
      write_reg(mg3_pkg::CSR_FRAME_WIDTH, 11'd2047);
      write_reg(mg3_pkg::CSR_FRAME_HEIGHT, 11'd1024);
      for (int i = 0; i < mg3_pkg::MAX_WIDTH + 16; i++)
         issue(mg3_pkg::OP_PIXEL, mg3_pkg::PIXEL_BITS'($urandom_range(0, 255)));

      // random frames, mostly complete with a full drain
      useful_items = 0;
      force_cfg    = 1'b1;
      while (useful_items < RANDOM_ITEMS) begin
         if (force_cfg || $urandom_range(0, 2) == 0) begin
            u  = $urandom_range(0, 99);
            wv = mg3_pkg::CSR_DATA_BITS'((u < 5)  ? 0 :
                                         (u < 35) ? $urandom_range(1, 4) :
                                         (u < 90) ? $urandom_range(5, 16) :
                                                    $urandom_range(17, 40));
            u  = $urandom_range(0, 99);
            hv = mg3_pkg::CSR_DATA_BITS'((u < 5)  ? 0 :
                                         (u < 40) ? $urandom_range(1, 3) :
                                         (u < 90) ? $urandom_range(4, 8) :
                                         (u < 94) ? 1024 :
                                         (u < 97) ? 2047 : $urandom_range(1000, 1023));
            settle();
            if (!force_cfg && $urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 1) == 0) write_reg(mg3_pkg::CSR_FRAME_WIDTH, wv);
               else write_reg(mg3_pkg::CSR_FRAME_HEIGHT, hv);
            end else begin
               write_reg(mg3_pkg::CSR_FRAME_WIDTH, wv);
               write_reg(mg3_pkg::CSR_FRAME_HEIGHT, hv);
            end
            force_cfg = 1'b0;
         end
         w         = active_width();
         npix      = w * active_height();
         truncated = (npix > 400);
         nsend     = truncated ? w * $urandom_range(2, 6) + $urandom_range(0, w - 1) : npix;
         steady_sender = ($urandom_range(0, 4) == 0);
         pattern_mode  = $urandom_range(0, 2);
         pattern_base  = $urandom_range(0, 248);
         hold_at       = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nsend) : -1;
         for (int i = 0; i < nsend; i++) begin
            // mid-frame pause until the pipeline is empty
            if (i == hold_at) settle();
            // early drain, ignored by the block
            if (i != 0 && $urandom_range(0, 32) == 0)
               issue(mg3_pkg::OP_DRAIN, mg3_pkg::PIXEL_BITS'($urandom));
            case (pattern_mode)
               0:       px = mg3_pkg::PIXEL_BITS'($urandom_range(0, 255));
               1:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default: px = mg3_pkg::PIXEL_BITS'(pattern_base + $urandom_range(0, 7));
            endcase
            issue(mg3_pkg::OP_PIXEL, px);
         end
         if (truncated) force_cfg = 1'b1;
         else begin
            // full flush, short flush that drops outputs, or surplus drains
            u      = $urandom_range(0, 99);
            ndrain = (u < 75) ? w + 1 :
                     (u < 88) ? $urandom_range(0, w) : w + 1 + $urandom_range(1, 3);
            for (int i = 0; i < ndrain; i++)
               issue(mg3_pkg::OP_DRAIN, mg3_pkg::PIXEL_BITS'($urandom));
         end
      end
      steady_sender = 1'b0;

      settle();
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
sv/mg3_pkg.sv
sv/mg3_ram.sv
sv/mg3_ctl.sv
sv/mg3_rows.sv
sv/mg3_out.sv
sv/morphological_gradient_3x3_top.sv
sim/tb_morphological_gradient_3x3_top.sv
